### rtl/nbes_pkg.sv
// Package for the NAND block erase sequencer: payload structs, the job record
// passed from front to back, configuration record, opcodes and codes.
// No dependencies.
package nbes_pkg;

  localparam int MAX_ROW_BYTES = 4;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] CMD_ERASE1 = 8'h60;
  localparam logic [7:0] CMD_ERASE2 = 8'hD0;
  localparam logic [7:0] CMD_STATUS = 8'h70;
  localparam logic [7:0] BYTE_MASK  = 8'hff;

  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_ADDR   = 2'd1;
  localparam logic [1:0] KIND_RESULT = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [1:0] REG_PPB_LOG2    = 2'd0;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd1;
  localparam logic [1:0] REG_TWO_PLANES  = 2'd2;
  localparam logic [1:0] REG_ROW_BYTES   = 2'd3;

  typedef struct packed {
    logic       mode;
    logic       erase_all;
    logic [7:0] status_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  cycle_kind;
    logic [7:0]  bus_byte;
    logic [15:0] block_index;
    logic        failed;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  pages_per_block_log2;
    logic [15:0] block_count;
    logic        two_planes;
    logic [2:0]  row_bytes;
  } cfg_t;

  // One unit of work for the back end: an optional block result, then either
  // a done report or a full erase operation starting at op_block.
  typedef struct packed {
    logic        has_result;
    logic [15:0] res_block;
    logic        res_failed;
    logic        has_done;
    logic [15:0] done_count;
    logic [15:0] op_block;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

### rtl/nbes_front.sv
// Front end of the erase sequencer: accepts items, keeps the block progress
// state and turns each effective item into a job. Depends on nbes_pkg.
module nbes_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  nbes_pkg::in_item_t    in_data,
  input  nbes_pkg::cfg_t        cfg,
  input  nbes_pkg::queue_status_t q_status,
  output logic                  push,
  output nbes_pkg::job_t        push_job
);

  logic [15:0] current_block_r, current_block_nxt;
  logic [15:0] blocks_to_erase_r, blocks_to_erase_nxt;
  logic        waiting_r, waiting_nxt;
  logic        accept;
  logic [15:0] start_count;
  logic [16:0] next_block;
  logic [15:0] second_sat;
  logic [15:0] next_sat;
  logic        status_done;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  assign start_count = in_data.erase_all ? cfg.block_count : 16'd1;
  assign next_block  = {1'b0, current_block_r} + 17'd1;
  assign next_sat    = next_block[16] ? 16'hffff : next_block[15:0];
  assign status_done = (next_block >= {1'b0, blocks_to_erase_r}) || next_block[16];

  always_comb begin
    current_block_nxt   = current_block_r;
    blocks_to_erase_nxt = blocks_to_erase_r;
    waiting_nxt         = waiting_r;
    push                = 1'b0;
    push_job            = '0;
    second_sat          = 16'd0;
    if (accept) begin
      if (!in_data.mode) begin
        if (!waiting_r) begin
          push                = 1'b1;
          blocks_to_erase_nxt = start_count;
          current_block_nxt   = 16'd0;
          if (start_count == 16'd0) begin
            push_job.has_done = 1'b1;
          end else begin
            push_job.op_block = 16'd0;
            waiting_nxt       = 1'b1;
            // With two planes the second block of the pair becomes current.
            if (cfg.two_planes) current_block_nxt = 16'd1;
          end
        end
      end else if (waiting_r) begin
        push                = 1'b1;
        waiting_nxt         = 1'b0;
        push_job.has_result = 1'b1;
        push_job.res_block  = current_block_r;
        push_job.res_failed = in_data.status_byte[0];
        if (status_done) begin
          push_job.has_done   = 1'b1;
          push_job.done_count = next_sat;
        end else begin
          push_job.op_block = next_block[15:0];
          waiting_nxt       = 1'b1;
          current_block_nxt = next_block[15:0];
          if (cfg.two_planes) begin
            second_sat        = (next_block[15:0] == 16'hffff) ? 16'hffff
                                                               : next_block[15:0] + 16'd1;
            current_block_nxt = second_sat;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_block_r   <= 16'd0;
      blocks_to_erase_r <= 16'd1;
      waiting_r         <= 1'b0;
    end else begin
      current_block_r   <= current_block_nxt;
      blocks_to_erase_r <= blocks_to_erase_nxt;
      waiting_r         <= waiting_nxt;
    end
  end

endmodule

### rtl/nbes_queue.sv
// Short job queue between the front and back ends of the erase sequencer.
// Depends on nbes_pkg.
module nbes_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  nbes_pkg::job_t          push_job,
  input  logic                    pop,
  output nbes_pkg::job_t          head_job,
  output nbes_pkg::queue_status_t status
);

  localparam int PW = $clog2(nbes_pkg::QUEUE_DEPTH);

  nbes_pkg::job_t  entry_r [nbes_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     count_r, count_nxt;

  assign status.full  = (count_r == (PW+1)'(nbes_pkg::QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign head_job     = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/nbes_back.sv
// Erase sequencer back end: walks each job through its bus cycles and reports
// into the output register, one result per cycle unless stalled. Uses nbes_pkg.
module nbes_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  nbes_pkg::cfg_t          cfg,
  input  nbes_pkg::job_t          job,
  input  nbes_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output nbes_pkg::out_item_t     out_data
);

  localparam logic [3:0] PH_BEGIN  = 4'd0;
  localparam logic [3:0] PH_RESULT = 4'd1;
  localparam logic [3:0] PH_DONE   = 4'd2;
  localparam logic [3:0] PH_E1A    = 4'd3;
  localparam logic [3:0] PH_ADDRA  = 4'd4;
  localparam logic [3:0] PH_E1B    = 4'd5;
  localparam logic [3:0] PH_ADDRB  = 4'd6;
  localparam logic [3:0] PH_E2     = 4'd7;
  localparam logic [3:0] PH_STATUS = 4'd8;

  logic [3:0]          phase_r, phase_nxt, cur_phase;
  logic [1:0]          byte_r, byte_nxt;
  logic                out_valid_r;
  nbes_pkg::out_item_t out_data_r, item;
  logic                load, emit, item_last;
  logic [2:0]          addr_cnt;
  logic                last_byte;
  logic [16:0]         blk_a, blk_b, addr_blk;
  logic [15:0]         idx_b;
  logic [31:0]         row;
  logic [3:0]          after_a, after_b;

  assign addr_cnt  = (cfg.row_bytes > 3'(nbes_pkg::MAX_ROW_BYTES))
                     ? 3'(nbes_pkg::MAX_ROW_BYTES) : cfg.row_bytes;
  assign last_byte = ({1'b0, byte_r} == addr_cnt - 3'd1);

  assign blk_a = {1'b0, job.op_block};
  assign blk_b = blk_a + 17'd1;
  assign idx_b = blk_b[16] ? 16'hffff : blk_b[15:0];

  assign addr_blk = (cur_phase == PH_ADDRB) ? blk_b : blk_a;
  assign row      = {15'd0, addr_blk} << cfg.pages_per_block_log2;

  assign after_a = cfg.two_planes ? PH_E1B : PH_E2;
  assign after_b = PH_E2;

  assign load = !out_valid_r || !out_stall;
  assign emit = !q_status.empty && load;
  assign pop  = emit && item_last;

  // The first phase of a job depends on which parts it carries.
  always_comb begin
    if (phase_r != PH_BEGIN) cur_phase = phase_r;
    else if (job.has_result) cur_phase = PH_RESULT;
    else if (job.has_done) cur_phase = PH_DONE;
    else cur_phase = PH_E1A;
  end

  always_comb begin
    item      = '0;
    phase_nxt = phase_r;
    byte_nxt  = byte_r;
    item_last = 1'b0;
    unique case (cur_phase)
      PH_RESULT: begin
        item.cycle_kind  = nbes_pkg::KIND_RESULT;
        item.block_index = job.res_block;
        item.failed      = job.res_failed;
        phase_nxt        = job.has_done ? PH_DONE : PH_E1A;
      end
      PH_DONE: begin
        item.cycle_kind  = nbes_pkg::KIND_DONE;
        item.block_index = job.done_count;
        item_last        = 1'b1;
        phase_nxt        = PH_BEGIN;
      end
      PH_E1A: begin
        item.cycle_kind  = nbes_pkg::KIND_CMD;
        item.bus_byte    = nbes_pkg::CMD_ERASE1;
        item.block_index = job.op_block;
        byte_nxt         = 2'd0;
        phase_nxt        = (addr_cnt != 3'd0) ? PH_ADDRA : after_a;
      end
      PH_ADDRA: begin
        item.cycle_kind  = nbes_pkg::KIND_ADDR;
        item.bus_byte    = row[{byte_r, 3'b000} +: 8] & nbes_pkg::BYTE_MASK;
        item.block_index = job.op_block;
        byte_nxt         = byte_r + 2'd1;
        phase_nxt        = last_byte ? after_a : PH_ADDRA;
      end
      PH_E1B: begin
        item.cycle_kind  = nbes_pkg::KIND_CMD;
        item.bus_byte    = nbes_pkg::CMD_ERASE1;
        item.block_index = idx_b;
        byte_nxt         = 2'd0;
        phase_nxt        = (addr_cnt != 3'd0) ? PH_ADDRB : after_b;
      end
      PH_ADDRB: begin
        item.cycle_kind  = nbes_pkg::KIND_ADDR;
        item.bus_byte    = row[{byte_r, 3'b000} +: 8] & nbes_pkg::BYTE_MASK;
        item.block_index = idx_b;
        byte_nxt         = byte_r + 2'd1;
        phase_nxt        = last_byte ? after_b : PH_ADDRB;
      end
      PH_E2: begin
        item.cycle_kind  = nbes_pkg::KIND_CMD;
        item.bus_byte    = nbes_pkg::CMD_ERASE2;
        item.block_index = cfg.two_planes ? idx_b : job.op_block;
        phase_nxt        = PH_STATUS;
      end
      PH_STATUS: begin
        item.cycle_kind  = nbes_pkg::KIND_CMD;
        item.bus_byte    = nbes_pkg::CMD_STATUS;
        item.block_index = cfg.two_planes ? idx_b : job.op_block;
        item_last        = 1'b1;
        phase_nxt        = PH_BEGIN;
      end
      default: begin
        phase_nxt = PH_BEGIN;
      end
    endcase
    item.last = item_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BEGIN;
      byte_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        phase_r <= phase_nxt;
        byte_r  <= byte_nxt;
      end
      if (load) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data_r <= item;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/nand_block_erase_sequencer_unit.sv
// Top level of the NAND block erase sequencer: configuration registers and
// the front end, job queue and back end. Depends on nbes_pkg, nbes_front,
// nbes_queue and nbes_back.
//
// Usage: the input channel (in_valid, in_stall, in_data) takes start items
// (mode 0) and device status items (mode 1). Each effective item yields a
// train of result items on the output channel (out_valid, out_stall,
// out_data): ERASE1 commands and row address cycles, ERASE2 and STATUS, and
// block results and a done report. The final item of each train has last set.
// Items that have no effect (a start while a status is awaited, a status
// while idle) are taken and produce nothing.
// The first result of an item is registered in the job queue, then in the output register.
// Throughput: the back end sends one result per cycle while the receiver does
// not stall; an effective item causes from 1 up to 13 results (two planes,
// four address cycles each).
// A two-entry job queue lets input be taken while earlier work drains; the
// input stalls only when the queue is full.
// When the receiver stalls, the output register holds its item and the back
// end waits. Synchronous reset returns the sequencer to idle, empties the
// queue and loads the configuration defaults.
module nand_block_erase_sequencer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  nbes_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output nbes_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  nbes_pkg::cfg_t          cfg_r;
  nbes_pkg::job_t          push_job, head_job;
  nbes_pkg::queue_status_t q_status;
  logic                    push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pages_per_block_log2 <= 4'd6;
      cfg_r.block_count          <= 16'd1024;
      cfg_r.two_planes           <= 1'b0;
      cfg_r.row_bytes            <= 3'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nbes_pkg::REG_PPB_LOG2:    cfg_r.pages_per_block_log2 <= cfg_wdata[3:0];
        nbes_pkg::REG_BLOCK_COUNT: cfg_r.block_count          <= cfg_wdata;
        nbes_pkg::REG_TWO_PLANES:  cfg_r.two_planes           <= cfg_wdata[0];
        nbes_pkg::REG_ROW_BYTES:   cfg_r.row_bytes            <= cfg_wdata[2:0];
      endcase
    end
  end

  nbes_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  nbes_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  nbes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job       (head_job),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### bench/nbes_checker.sv
// Checker for the NAND block erase sequencer: follows the register writes and
// the input channel, predicts every bus cycle and result, and compares them
// with the output channel. Depends on nbes_pkg.
module nbes_checker
  import nbes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          pending,
  output logic        awaiting_status
);
  timeunit 1ns;
  timeprecision 1ps;

  out_item_t   expected_cycles[$];

  logic [3:0]  ppb_log2;
  logic [15:0] blk_count;
  logic        plane_pair;
  logic [2:0]  row_cycles;

  int unsigned cur_block;
  int unsigned blocks_left;

  function automatic void emit_cycle(input logic [1:0] kind, input logic [7:0] bus,
                                     input int unsigned idx, input logic fail);
    out_item_t c;
    c.cycle_kind  = kind;
    c.bus_byte    = bus;
    c.block_index = (idx > 32'hffff) ? 16'hffff : idx[15:0];
    c.failed      = fail;
    c.last        = 1'b0;
    expected_cycles.push_back(c);
  endfunction

  // ERASE1 and then the row address, low byte first; bytes past the top of
  // the row address come out as zero.
  function automatic void emit_block_address(input int unsigned blk);
    logic [63:0] row;
    int          cnt;
    row = 64'(blk) << ppb_log2;
    cnt = (row_cycles > MAX_ROW_BYTES) ? MAX_ROW_BYTES : int'(row_cycles);
    emit_cycle(KIND_CMD, CMD_ERASE1, blk, 1'b0);
    for (int j = 0; j < cnt; j++) begin
      emit_cycle(KIND_ADDR, row[j*8 +: 8], blk, 1'b0);
    end
  endfunction

  function automatic void emit_erase_op();
    int unsigned second;
    emit_block_address(cur_block);
    if (plane_pair) begin
      second = cur_block + 1;
      emit_block_address(second);
      cur_block = (second > 32'hffff) ? 32'hffff : second;
    end
    emit_cycle(KIND_CMD, CMD_ERASE2, cur_block, 1'b0);
    emit_cycle(KIND_CMD, CMD_STATUS, cur_block, 1'b0);
    awaiting_status = 1'b1;
  endfunction

  task automatic predict_bus_cycles(input in_item_t it);
    int          before_cnt;
    int unsigned next_blk;
    out_item_t   tail;
    before_cnt = expected_cycles.size();
    if (it.mode == 1'b0) begin
      // A start while a status is awaited is dropped.
      if (!awaiting_status) begin
        blocks_left = it.erase_all ? 32'(blk_count) : 32'd1;
        cur_block   = 0;
        if (blocks_left == 0) begin
          emit_cycle(KIND_DONE, 8'h00, 0, 1'b0);
        end else begin
          emit_erase_op();
        end
      end
    end else if (awaiting_status) begin
      awaiting_status = 1'b0;
      emit_cycle(KIND_RESULT, 8'h00, cur_block, it.status_byte[0]);
      next_blk = cur_block + 1;
      if (next_blk >= blocks_left || next_blk > 32'hffff) begin
        emit_cycle(KIND_DONE, 8'h00, next_blk, 1'b0);
      end else begin
        cur_block = next_blk;
        emit_erase_op();
      end
    end
    if (expected_cycles.size() > before_cnt) begin
      tail = expected_cycles.pop_back();
      tail.last = 1'b1;
      expected_cycles.push_back(tail);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      ppb_log2        = 4'd6;
      blk_count       = 16'd1024;
      plane_pair      = 1'b0;
      row_cycles      = 3'd3;
      cur_block       = 0;
      blocks_left     = 1;
      awaiting_status = 1'b0;
      expected_cycles.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cycles.size() == 0) begin
          report_mismatch($sformatf(
            "result item with none outstanding: kind %0d byte %02h block %0d",
            out_data.cycle_kind, out_data.bus_byte, out_data.block_index));
        end else begin
          want = expected_cycles.pop_front();
          if (out_data !== want) begin
            report_mismatch($sformatf(
              "bad result item: got %0d %02h %0d %0b %0b, want %0d %02h %0d %0b %0b",
              out_data.cycle_kind, out_data.bus_byte, out_data.block_index, out_data.failed,
              out_data.last, want.cycle_kind, want.bus_byte, want.block_index, want.failed,
              want.last));
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_bus_cycles(in_data);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PPB_LOG2:    ppb_log2   = cfg_wdata[3:0];
          REG_BLOCK_COUNT: blk_count  = cfg_wdata;
          REG_TWO_PLANES:  plane_pair = cfg_wdata[0];
          REG_ROW_BYTES:   row_cycles = cfg_wdata[2:0];
          default: ;
        endcase
      end
    end
    pending = expected_cycles.size();
  end

endmodule

### bench/tb_nand_block_erase_sequencer_unit.sv
// Testbench top for the NAND block erase sequencer: clock, reset, register
// writes, input items and receiver stalls, and the verdict. Depends on
// nbes_pkg, nbes_checker and nand_block_erase_sequencer_unit.
module tb_nand_block_erase_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import nbes_pkg::*;

  localparam int STIM_ITEMS     = 290;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  int          mismatches;
  int          pending;
  logic        awaiting_status;
  logic        quiet = 1'b0;
  int          idle_cycles = 0;
  int          random_items = 0;

  always #1 clk = ~clk;

  nand_block_erase_sequencer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nbes_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .awaiting_status (awaiting_status)
  );

  always @(negedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 32);
  end

  // Ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t start_item(input logic all);
    in_item_t it;
    it.mode        = 1'b0;
    it.erase_all   = all;
    it.status_byte = 8'($urandom_range(255));
    return it;
  endfunction

  function automatic in_item_t status_item(input logic [7:0] sb);
    in_item_t it;
    it.mode        = 1'b1;
    it.erase_all   = 1'($urandom_range(1));
    it.status_byte = sb;
    return it;
  endfunction

  // Called and returns at a falling edge; the item is held until taken.
  task automatic push_item(input in_item_t it);
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all four registers; unused upper bits of the write data are noise.
  task automatic apply_settings(input logic [3:0] ppb, input logic [15:0] bc,
                                input logic tp, input logic [2:0] rb);
    logic [15:0] vals [4];
    vals[REG_PPB_LOG2]    = {12'($urandom), ppb};
    vals[REG_BLOCK_COUNT] = bc;
    vals[REG_TWO_PLANES]  = {15'($urandom), tp};
    vals[REG_ROW_BYTES]   = {13'($urandom), rb};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // A start, then status items until the erase is done. When noisy, a dropped
  // status may lead, dropped starts mix in and the sequence may be abandoned.
  task automatic erase_run(input logic all, input bit noisy);
    if (noisy && !awaiting_status && $urandom_range(99) < 8) begin
      push_item(status_item(8'($urandom_range(255))));
    end
    push_item(start_item(all));
    random_items++;
    while (awaiting_status) begin
      if (noisy && $urandom_range(99) < 8) begin
        push_item(start_item(1'($urandom_range(1))));
      end
      if (noisy && $urandom_range(99) < 5) begin
        break;
      end
      push_item(status_item(8'($urandom_range(255))));
      random_items++;
    end
  endtask

  initial begin
    int          r;
    logic [15:0] bc;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: a status while idle and a start while waiting are dropped.
    push_item(status_item(8'h00));
    push_item(start_item(1'b0));
    push_item(start_item(1'b1));
    push_item(status_item(8'hff));

    // Two planes, widest shift, four address cycles, odd count pairs past it.
    settle();
    apply_settings(4'd15, 16'd3, 1'b1, 3'd4);
    push_item(start_item(1'b1));
    push_item(status_item(8'h01));
    push_item(status_item(8'hfe));

    // Zero count gives a bare done; row bytes above the maximum saturate.
    settle();
    apply_settings(4'd0, 16'd0, 1'b0, 3'd7);
    push_item(start_item(1'b1));
    push_item(start_item(1'b0));
    push_item(status_item(8'haa));

    // No address cycles at all.
    settle();
    apply_settings(4'd9, 16'hffff, 1'b0, 3'd0);
    push_item(start_item(1'b0));
    push_item(status_item(8'h55));

    settle();
    apply_settings(4'd15, 16'd2, 1'b0, 3'd5);
    push_item(start_item(1'b1));
    push_item(status_item(8'h80));
    push_item(status_item(8'h01));

    settle();
    apply_settings(4'd1, 16'd1, 1'b1, 3'd6);
    push_item(start_item(1'b1));
    push_item(status_item(8'h7f));

    while (random_items < STIM_ITEMS) begin
      settle();
      r = $urandom_range(99);
      if (r < 8) begin
        bc = 16'd0;
      end else if (r < 90) begin
        bc = 16'($urandom_range(1, 8));
      end else begin
        bc = 16'($urandom_range(9, 24));
      end
      apply_settings(4'($urandom_range(15)), bc, 1'($urandom_range(1)),
                     3'($urandom_range(7)));
      quiet <= ($urandom_range(99) < 10);
      repeat ($urandom_range(1, 3)) erase_run(1'($urandom_range(1)), 1'b1);
    end

    // A long whole-chip erase run flat out with no idling on either side.
    while (awaiting_status) push_item(status_item(8'($urandom_range(255))));
    settle();
    apply_settings(4'($urandom_range(15)), 16'd48, 1'b0, 3'd4);
    quiet <= 1'b1;
    erase_run(1'b1, 1'b0);
    quiet <= 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/nbes_pkg.sv
rtl/nbes_front.sv
rtl/nbes_queue.sv
rtl/nbes_back.sv
rtl/nand_block_erase_sequencer_unit.sv
bench/nbes_checker.sv
bench/tb_nand_block_erase_sequencer_unit.sv
